/* sv/rvx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared opcodes, status codes and sequencer states of the RV32IM execute unit.
// ----------------------------------------------------------------------------
package rvx_pkg;

   localparam int XLEN     = 32;
   localparam int NUM_REGS = 32;
   localparam int REG_AW   = 5;

   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;
   localparam logic [6:0] F7_MULD = 7'h01;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SRL  = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_MUL  = 3'd0;
   localparam logic [2:0] F3_MULH = 3'd1;
   localparam logic [2:0] F3_DIV  = 3'd4;
   localparam logic [2:0] F3_REM  = 3'd6;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_INVALID    = 2'd1,
      ST_DIVZERO    = 2'd2,
      ST_NOTHANDLED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_A,
      S_READ_B,
      S_EXEC,
      S_MULDIV,
      S_FIXUP,
      S_RESP
   } state_type;

endpackage

/* sv/rvx_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rvx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/rv32im_execute_unit_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32im_execute_unit_core
// RV32IM integer execute unit: register file in RAM, 33-bit adder for
// multiply steps and 33-bit subtractor for divide steps. States: S_READ_A,
// S_READ_B, S_EXEC, S_RESP; mul, mulh, div and rem add S_MULDIV (32
// shift-add or restoring-subtract steps) and S_FIXUP. One instruction at
// a time; the next is taken once the result has moved into the output
// register. Register file reads of rs1 and rs2 are sequential (one port).
// Reset clears the register file valid bits, the PC and reset_pc to zero.
// ----------------------------------------------------------------------------
module rv32im_execute_unit_core
   import rvx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_write_value,
   output logic        rsp_branch_taken,
   output logic [1:0]  rsp_status
);

   state_type state_ff, state_in;

   logic [31:0]       reset_pc_ff;
   logic [31:0]       pc_ff;
   logic [31:0]       instr_ff;
   logic [31:0]       a_ff;
   logic [31:0]       b_ff;
   logic [NUM_REGS-1:0] valid_ff;
   logic [4:0]        ram_raddr_ff;
   logic [4:0]        cnt_ff;
   logic [31:0]       hi_ff;
   logic [31:0]       lo_ff;
   logic [31:0]       dvs_ff;
   logic              is_mul_ff;

   logic [31:0]       pnd_npc_ff;
   logic              pnd_wr_ff;
   logic [4:0]        pnd_rd_ff;
   logic [31:0]       pnd_val_ff;
   logic              pnd_taken_ff;
   status_type        pnd_status_ff;

   logic              rsp_valid_ff;
   logic [31:0]       rsp_npc_ff;
   logic              rsp_wr_ff;
   logic [4:0]        rsp_rd_ff;
   logic [31:0]       rsp_val_ff;
   logic              rsp_taken_ff;
   status_type        rsp_status_ff;

   logic [6:0]  opc;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [4:0]  rs1;
   logic [4:0]  rs2;
   logic [31:0] immi;
   logic [31:0] immb;
   logic [31:0] immj;
   logic [31:0] immu;
   logic [31:0] ram_rdata;
   logic [31:0] rf_data;
   logic [4:0]  ram_raddr;
   logic        ram_we;

   logic [31:0] op2;
   logic [4:0]  shamt;
   logic [31:0] ex_val;
   logic [31:0] ex_npc;
   logic        ex_wr;
   logic        ex_taken;
   status_type  ex_status;
   logic        ex_muldiv;
   logic        ex_mul;
   logic        cond;

   logic [32:0] mul_sum;
   logic [32:0] div_shift;
   logic [32:0] div_diff;
   logic [63:0] prod;
   logic [63:0] prod_neg;
   logic [31:0] fx_val;

   logic        commit;
   logic        out_free;

   assign opc   = instr_ff[6:0];
   assign rd    = instr_ff[11:7];
   assign f3    = instr_ff[14:12];
   assign rs1   = instr_ff[19:15];
   assign rs2   = instr_ff[24:20];
   assign f7    = instr_ff[31:25];
   assign immi  = {{20{instr_ff[31]}}, instr_ff[31:20]};
   assign immb  = {{19{instr_ff[31]}}, instr_ff[31], instr_ff[7], instr_ff[30:25],
                   instr_ff[11:8], 1'b0};
   assign immj  = {{11{instr_ff[31]}}, instr_ff[31], instr_ff[19:12], instr_ff[20],
                   instr_ff[30:21], 1'b0};
   assign immu  = {instr_ff[31:12], 12'h000};

   // Register file
   assign ram_raddr = (state_ff == S_READ_A) ? rs1 : rs2;
   assign ram_we    = commit && pnd_wr_ff;
   assign rf_data   = valid_ff[ram_raddr_ff] ? ram_rdata : '0;

   rvx_ram #(
      .WIDTH(XLEN),
      .DEPTH(NUM_REGS)
   ) u_regfile (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(pnd_rd_ff),
      .wr_data(pnd_val_ff),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Decode and combinational execute
   always_comb begin
      op2       = (opc == OPC_OP_IMM) ? immi : rf_data;
      shamt     = (opc == OPC_OP_IMM) ? instr_ff[24:20] : rf_data[4:0];
      ex_val    = '0;
      ex_npc    = pc_ff + 32'd4;
      ex_wr     = 1'b0;
      ex_taken  = 1'b0;
      ex_status = ST_OK;
      ex_muldiv = 1'b0;
      ex_mul    = 1'b0;
      cond      = 1'b0;
      case (opc)
         OPC_OP, OPC_OP_IMM: begin
            ex_wr = 1'b1;
            if (opc == OPC_OP && f7 == F7_MULD) begin
               case (f3)
                  F3_MUL, F3_MULH: begin
                     ex_muldiv = 1'b1;
                     ex_mul    = 1'b1;
                  end
                  F3_DIV, F3_REM: begin
                     if (rf_data == '0) begin
                        ex_wr     = 1'b0;
                        ex_status = ST_DIVZERO;
                     end else begin
                        ex_muldiv = 1'b1;
                     end
                  end
                  default: begin
                     ex_wr     = 1'b0;
                     ex_status = ST_INVALID;
                  end
               endcase
            end else if (opc == OPC_OP && f7 != F7_BASE &&
                         !(f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SRL))) begin
               ex_wr     = 1'b0;
               ex_status = ST_INVALID;
            end else if (opc == OPC_OP_IMM && f3 == F3_SLL && f7 != F7_BASE) begin
               ex_wr     = 1'b0;
               ex_status = ST_INVALID;
            end else if (opc == OPC_OP_IMM && f3 == F3_SRL && f7 != F7_BASE &&
                         f7 != F7_ALT) begin
               ex_wr     = 1'b0;
               ex_status = ST_INVALID;
            end else begin
               case (f3)
                  F3_ADD: begin
                     if (opc == OPC_OP && f7 == F7_ALT) begin
                        ex_val = a_ff - op2;
                     end else begin
                        ex_val = a_ff + op2;
                     end
                  end
                  F3_SLL:  ex_val = a_ff << shamt;
                  F3_SLT:  ex_val = {31'd0, $signed(a_ff) < $signed(op2)};
                  F3_SLTU: ex_val = {31'd0, a_ff < op2};
                  F3_XOR:  ex_val = a_ff ^ op2;
                  F3_SRL: begin
                     if (f7 == F7_ALT) begin
                        ex_val = $unsigned($signed(a_ff) >>> shamt);
                     end else begin
                        ex_val = a_ff >> shamt;
                     end
                  end
                  F3_OR:   ex_val = a_ff | op2;
                  default: ex_val = a_ff & op2;
               endcase
            end
         end
         OPC_JALR: begin
            if (f3 == 3'd0) begin
               ex_wr    = 1'b1;
               ex_val   = pc_ff + 32'd4;
               ex_npc   = (a_ff + immi) & ~32'd1;
               ex_taken = 1'b1;
            end else begin
               ex_status = ST_INVALID;
            end
         end
         OPC_BRANCH: begin
            case (f3)
               F3_BEQ:  cond = (a_ff == rf_data);
               F3_BNE:  cond = (a_ff != rf_data);
               F3_BLT:  cond = ($signed(a_ff) < $signed(rf_data));
               F3_BGE:  cond = !($signed(a_ff) < $signed(rf_data));
               F3_BLTU: cond = (a_ff < rf_data);
               F3_BGEU: cond = (a_ff >= rf_data);
               default: ex_status = ST_INVALID;
            endcase
            if (cond) begin
               ex_taken = 1'b1;
               ex_npc   = pc_ff + immb;
            end
         end
         OPC_AUIPC: begin
            ex_wr  = 1'b1;
            ex_val = pc_ff + immu;
         end
         OPC_LUI: begin
            ex_wr  = 1'b1;
            ex_val = immu;
         end
         OPC_JAL: begin
            ex_wr    = 1'b1;
            ex_val   = pc_ff + 32'd4;
            ex_npc   = pc_ff + immj;
            ex_taken = 1'b1;
         end
         OPC_LOAD, OPC_STORE, OPC_SYSTEM: ex_status = ST_NOTHANDLED;
         default: ex_status = ST_INVALID;
      endcase
   end

   // Multiply adder and divide subtractor steps
   assign mul_sum   = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, dvs_ff} : 33'd0);
   assign div_shift = {hi_ff, lo_ff[31]};
   assign div_diff  = div_shift - {1'b0, dvs_ff};
   assign prod      = {hi_ff, lo_ff};
   assign prod_neg  = 64'd0 - prod;

   always_comb begin
      if (is_mul_ff) begin
         if (a_ff[31] ^ b_ff[31]) begin
            fx_val = (f3 == F3_MUL) ? prod_neg[31:0] : prod_neg[63:32];
         end else begin
            fx_val = (f3 == F3_MUL) ? prod[31:0] : prod[63:32];
         end
      end else if (f3 == F3_DIV) begin
         fx_val = (a_ff[31] ^ b_ff[31]) ? 32'd0 - lo_ff : lo_ff;
      end else begin
         fx_val = a_ff[31] ? 32'd0 - hi_ff : hi_ff;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = (state_ff == S_RESP) && out_free;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_READ_A;
         S_READ_A: state_in = S_READ_B;
         S_READ_B: state_in = S_EXEC;
         S_EXEC:   state_in = ex_muldiv ? S_MULDIV : S_RESP;
         S_MULDIV: if (cnt_ff == 5'd31) state_in = S_FIXUP;
         S_FIXUP:  state_in = S_RESP;
         S_RESP:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_pc_ff  <= '0;
         pc_ff        <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            reset_pc_ff <= csr_wr_data;
         end
         if (commit) begin
            pc_ff        <= pnd_npc_ff;
            rsp_valid_ff <= 1'b1;
            if (pnd_wr_ff) begin
               valid_ff[pnd_rd_ff] <= 1'b1;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ram_raddr_ff <= ram_raddr;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               instr_ff <= req_instr_word;
            end
         end
         S_READ_B: a_ff <= rf_data;
         S_EXEC: begin
            b_ff      <= rf_data;
            cnt_ff    <= '0;
            is_mul_ff <= ex_mul;
            hi_ff     <= '0;
            lo_ff     <= a_ff[31] ? 32'd0 - a_ff : a_ff;
            dvs_ff    <= rf_data[31] ? 32'd0 - rf_data : rf_data;
            if (ex_wr && rd != 5'd0) begin
               pnd_wr_ff  <= 1'b1;
               pnd_rd_ff  <= rd;
               pnd_val_ff <= ex_val;
            end else begin
               pnd_wr_ff  <= 1'b0;
               pnd_rd_ff  <= '0;
               pnd_val_ff <= '0;
            end
            pnd_npc_ff    <= ex_npc;
            pnd_taken_ff  <= ex_taken;
            pnd_status_ff <= ex_status;
         end
         S_MULDIV: begin
            cnt_ff <= cnt_ff + 5'd1;
            if (is_mul_ff) begin
               hi_ff <= mul_sum[32:1];
               lo_ff <= {mul_sum[0], lo_ff[31:1]};
            end else if (!div_diff[32]) begin
               hi_ff <= div_diff[31:0];
               lo_ff <= {lo_ff[30:0], 1'b1};
            end else begin
               hi_ff <= div_shift[31:0];
               lo_ff <= {lo_ff[30:0], 1'b0};
            end
         end
         S_FIXUP: begin
            if (pnd_wr_ff) begin
               pnd_val_ff <= fx_val;
            end
         end
         default: begin
         end
      endcase
      if (commit) begin
         rsp_npc_ff    <= pnd_npc_ff;
         rsp_wr_ff     <= pnd_wr_ff;
         rsp_rd_ff     <= pnd_rd_ff;
         rsp_val_ff    <= pnd_val_ff;
         rsp_taken_ff  <= pnd_taken_ff;
         rsp_status_ff <= pnd_status_ff;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = rsp_npc_ff;
   assign rsp_reg_written  = rsp_wr_ff;
   assign rsp_dest_index   = rsp_rd_ff;
   assign rsp_write_value  = rsp_val_ff;
   assign rsp_branch_taken = rsp_taken_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTHESIS
   a_pc_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> pc_ff == reset_pc_ff)
      else $error("PC does not hold the reset value after reset");

   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_wr_ff |-> rsp_rd_ff != 5'd0)
      else $error("write to x0 reported");

   a_no_write_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_wr_ff |-> rsp_rd_ff == 5'd0 && rsp_val_ff == 32'd0)
      else $error("write fields not cleared without a write");

   a_divzero_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_DIVZERO |-> !rsp_wr_ff && !rsp_taken_ff)
      else $error("divide by zero wrote a register or redirected");
`endif

endmodule
